FILE: sv/gsd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gsd_pkg
// Shared types and constants of the swipe gesture detector.
// ----------------------------------------------------------------------------
package gsd_pkg;

    localparam int unsigned DELTA_W = 32;
    localparam int unsigned TIME_W  = 63;
    localparam int unsigned DEAD_W  = 64;
    localparam int unsigned CFG_W   = 32;
    localparam int unsigned IDX_W   = 8;

    localparam logic [IDX_W-1:0] CFG_THRESHOLD = 8'd0;
    localparam logic [IDX_W-1:0] CFG_COOLDOWN  = 8'd1;

    localparam logic AXIS_X = 1'b0;
    localparam logic AXIS_Y = 1'b1;

    typedef enum logic [2:0] {
        DIR_NONE  = 3'd0,
        DIR_LEFT  = 3'd1,
        DIR_RIGHT = 3'd2,
        DIR_UP    = 3'd3,
        DIR_DOWN  = 3'd4
    } t_dir;

    typedef struct packed {
        logic                      axis_select;
        logic signed [DELTA_W-1:0] motion_delta;
        logic                      sync_flag;
        logic [TIME_W-1:0]         time_now;
    } t_report;

endpackage
`default_nettype wire

FILE: sv/swipe_gesture_detector_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swipe_gesture_detector_top
// Turns a stream of relative motion reports into swipe directions.
// ----------------------------------------------------------------------------
// Takes one motion report per clock unless the output stalls and returns
// exactly one direction request per report, in order. The rate is set by the
// single evaluation stage, which updates the X/Y accumulators and cooldown
// state once per cycle; each report passes an input register and then a result
// register, which decouple both stream sides so back-to-back requests flow
// while a finished result waits. Configuration writes are always accepted.
// ----------------------------------------------------------------------------
module swipe_gesture_detector_top (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // slave side
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [95:0] i_s_tdata,   // [31:0] motion_delta, [94:32] time_now, [95] unused
    input  wire         i_s_tuser,   // [0] axis_select
    input  wire         i_s_tlast,   // sync_flag
    // master side
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [7:0]  o_m_tdata,   // [2:0] direction, [7:3] zero
    // configuration
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [7:0]  i_cfg_index,
    input  wire  [31:0] i_cfg_data
);

    gsd_pkg::t_report in_report;
    gsd_pkg::t_report core_report;
    logic             core_valid;
    logic             core_advance;
    gsd_pkg::t_dir    dir;

    assign in_report.axis_select  = i_s_tuser;
    assign in_report.motion_delta = i_s_tdata[31:0];
    assign in_report.sync_flag    = i_s_tlast;
    assign in_report.time_now     = i_s_tdata[94:32];

    assign o_cfg_ready = 1'b1;
    assign o_m_tdata   = {5'b0, dir};

    gsd_in_stage u_in (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_tvalid),
        .o_ready  (o_s_tready),
        .i_report (in_report),
        .o_valid  (core_valid),
        .i_advance(core_advance),
        .o_report (core_report)
    );

    gsd_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (core_valid),
        .i_report   (core_report),
        .o_advance  (core_advance),
        .i_cfg_valid(i_cfg_valid),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .o_valid    (o_m_tvalid),
        .i_ready    (i_m_tready),
        .o_dir      (dir)
    );

endmodule
`default_nettype wire

FILE: sv/gsd_in_stage.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gsd_in_stage
// Input register: holds one motion report until the evaluation stage takes it.
// ----------------------------------------------------------------------------
module gsd_in_stage (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    output logic             o_ready,
    input  wire gsd_pkg::t_report i_report,
    output logic             o_valid,
    input  wire              i_advance,
    output gsd_pkg::t_report o_report
);

    logic             r_valid;
    gsd_pkg::t_report r_report;
    logic             n_valid;

    assign o_ready  = !r_valid || i_advance;
    assign o_valid  = r_valid;
    assign o_report = r_report;

    always_comb begin
        n_valid = r_valid;
        if (i_valid && o_ready) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_report <= i_report;
        end
    end

endmodule
`default_nettype wire

FILE: sv/gsd_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gsd_core
// Accumulators, cooldown tracking, gesture decision and result register.
// ----------------------------------------------------------------------------
module gsd_core (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_valid,
    input  wire gsd_pkg::t_report           i_report,
    output logic                            o_advance,
    input  wire                             i_cfg_valid,
    input  wire  [gsd_pkg::IDX_W-1:0]       i_cfg_index,
    input  wire  [gsd_pkg::CFG_W-1:0]       i_cfg_data,
    output logic                            o_valid,
    input  wire                             i_ready,
    output gsd_pkg::t_dir                   o_dir
);

    logic [gsd_pkg::CFG_W-1:0]          r_threshold;
    logic [gsd_pkg::CFG_W-1:0]          r_cooldown_time;
    logic signed [gsd_pkg::DELTA_W-1:0] r_acc_x;
    logic signed [gsd_pkg::DELTA_W-1:0] r_acc_y;
    logic                               r_cool;
    logic [gsd_pkg::DEAD_W-1:0]         r_deadline;
    logic                               r_out_valid;
    gsd_pkg::t_dir                      r_dir;

    logic signed [gsd_pkg::DELTA_W-1:0] n_acc_x;
    logic signed [gsd_pkg::DELTA_W-1:0] n_acc_y;
    logic                               n_cool;
    logic [gsd_pkg::DEAD_W-1:0]         n_deadline;
    gsd_pkg::t_dir                      n_dir;

    logic signed [gsd_pkg::DELTA_W-1:0] acc_sel;
    logic [gsd_pkg::DELTA_W:0]          sum;
    logic signed [gsd_pkg::DELTA_W-1:0] acc_sat;
    logic signed [gsd_pkg::DELTA_W-1:0] upd_x;
    logic signed [gsd_pkg::DELTA_W-1:0] upd_y;
    logic [gsd_pkg::DELTA_W-1:0]        abs_x;
    logic [gsd_pkg::DELTA_W-1:0]        abs_y;
    logic [gsd_pkg::DELTA_W:0]          mag;
    logic                               fire;

    assign o_advance = i_valid && (!r_out_valid || i_ready);
    assign o_valid   = r_out_valid;
    assign o_dir     = r_dir;

    always_comb begin
        acc_sel = (i_report.axis_select == gsd_pkg::AXIS_X) ? r_acc_x : r_acc_y;
        sum     = {acc_sel[gsd_pkg::DELTA_W-1], acc_sel}
                + {i_report.motion_delta[gsd_pkg::DELTA_W-1], i_report.motion_delta};
        if (sum[gsd_pkg::DELTA_W] != sum[gsd_pkg::DELTA_W-1]) begin
            acc_sat = sum[gsd_pkg::DELTA_W] ? {1'b1, {(gsd_pkg::DELTA_W-1){1'b0}}}
                                            : {1'b0, {(gsd_pkg::DELTA_W-1){1'b1}}};
        end else begin
            acc_sat = sum[gsd_pkg::DELTA_W-1:0];
        end
        upd_x = (i_report.axis_select == gsd_pkg::AXIS_X) ? acc_sat : r_acc_x;
        upd_y = (i_report.axis_select == gsd_pkg::AXIS_Y) ? acc_sat : r_acc_y;
        abs_x = upd_x[gsd_pkg::DELTA_W-1] ? (~upd_x + 1'b1) : upd_x;
        abs_y = upd_y[gsd_pkg::DELTA_W-1] ? (~upd_y + 1'b1) : upd_y;
        mag   = {1'b0, abs_x} + {1'b0, abs_y};
        fire  = i_report.sync_flag && (mag >= {1'b0, r_threshold});

        n_acc_x    = upd_x;
        n_acc_y    = upd_y;
        n_cool     = r_cool;
        n_deadline = r_deadline;
        n_dir      = gsd_pkg::DIR_NONE;

        if (r_cool) begin
            n_acc_x = '0;
            n_acc_y = '0;
            if (i_report.sync_flag && ({1'b0, i_report.time_now} >= r_deadline)) begin
                n_cool = 1'b0;
            end
        end else if (fire) begin
            if (abs_x >= abs_y) begin
                n_dir = upd_x[gsd_pkg::DELTA_W-1] ? gsd_pkg::DIR_LEFT : gsd_pkg::DIR_RIGHT;
            end else begin
                n_dir = upd_y[gsd_pkg::DELTA_W-1] ? gsd_pkg::DIR_UP : gsd_pkg::DIR_DOWN;
            end
            n_acc_x    = '0;
            n_acc_y    = '0;
            n_cool     = 1'b1;
            n_deadline = {1'b0, i_report.time_now}
                       + {{(gsd_pkg::DEAD_W-gsd_pkg::CFG_W){1'b0}}, r_cooldown_time};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold     <= '0;
            r_cooldown_time <= '0;
            r_acc_x         <= '0;
            r_acc_y         <= '0;
            r_cool          <= 1'b0;
            r_deadline      <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    gsd_pkg::CFG_THRESHOLD: r_threshold     <= i_cfg_data;
                    gsd_pkg::CFG_COOLDOWN:  r_cooldown_time <= i_cfg_data;
                    default: ;
                endcase
            end
            if (o_advance) begin
                r_acc_x     <= n_acc_x;
                r_acc_y     <= n_acc_y;
                r_cool      <= n_cool;
                r_deadline  <= n_deadline;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance) begin
            r_dir <= n_dir;
        end
    end

endmodule
`default_nettype wire

FILE: sv/gsd_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gsd_port_checks
// Port-level checks of the swipe gesture detector, bound to the top level.
// ----------------------------------------------------------------------------
module gsd_port_checks (
    input wire         i_clk,
    input wire         i_rst_n,
    input wire         o_s_tready,
    input wire         o_m_tvalid,
    input wire         i_m_tready,
    input wire  [7:0]  o_m_tdata
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("result request dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata))
        else $error("result payload changed while stalled");

    a_dir_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata <= 8'd4))
        else $error("illegal direction code");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid straight after reset");

    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid && !o_s_tready |=> o_m_tvalid)
        else $error("input stalled with empty output");

endmodule

bind swipe_gesture_detector_top gsd_port_checks u_gsd_port_checks (.*);
`default_nettype wire
